[design/cfi_pkg.sv]
package cfi_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int COEF_W        = 19;
   localparam int NIMP_W        = 31;
   localparam int LIM_W         = COEF_W + NIMP_W;
   localparam int SAT_IN_W      = 66;

   localparam logic [1:0] REGIME_NONE  = 2'd0;
   localparam logic [1:0] REGIME_STICK = 2'd1;
   localparam logic [1:0] REGIME_SLIDE = 2'd2;

   typedef struct packed {
      logic signed [WORD_W-1:0] normal_x;
      logic signed [WORD_W-1:0] normal_y;
      logic signed [WORD_W-1:0] normal_z;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
      logic signed [WORD_W-1:0] vel_z;
      logic [NIMP_W-1:0]        normal_impulse;
      logic signed [WORD_W-1:0] denom;
      logic [COEF_W-1:0]        static_coef;
      logic [COEF_W-1:0]        dynamic_coef;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] impulse_x;
      logic signed [WORD_W-1:0] impulse_y;
      logic signed [WORD_W-1:0] impulse_z;
      logic [1:0]               regime;
   } rsp_type;

   // saturate a wide signed value into 32 bits
   function automatic logic signed [WORD_W-1:0] sat_s32(input logic signed [SAT_IN_W-1:0] x);
      if (x[SAT_IN_W-1:WORD_W-1] == '0 || x[SAT_IN_W-1:WORD_W-1] == '1) begin
         return x[WORD_W-1:0];
      end
      return x[SAT_IN_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

endpackage

[design/cfi_isqrt.sv]
module cfi_isqrt #(
   parameter int RW     = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic [2*RW-1:0]   rad_st  [RW+1];
   logic [RW+1:0]     rem_st  [RW+1];
   logic [RW-1:0]     root_st [RW+1];
   logic [SIDE_W-1:0] side_st [RW+1];
   logic [RW:0]       valid_st;

   logic [2*RW-1:0]   rad_ff  [RW];
   logic [RW+1:0]     rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [SIDE_W-1:0] side_ff [RW];
   logic [RW-1:0]     valid_ff;

   logic [2*RW-1:0]   rad_in  [RW];
   logic [RW+1:0]     rem_in  [RW];
   logic [RW-1:0]     root_in [RW];

   always_comb begin
      rad_st[0]   = in_rad;
      rem_st[0]   = '0;
      root_st[0]  = '0;
      side_st[0]  = in_side;
      valid_st[0] = in_valid;
      for (int s = 0; s < RW; s++) begin
         rad_st[s+1]   = rad_ff[s];
         rem_st[s+1]   = rem_ff[s];
         root_st[s+1]  = root_ff[s];
         side_st[s+1]  = side_ff[s];
         valid_st[s+1] = valid_ff[s];
      end
   end

   // one result bit per stage: bring in two radicand bits, try 4*root+1
   always_comb begin
      logic [RW+3:0] cat;
      logic [RW+3:0] trial;
      logic          ge;
      for (int s = 0; s < RW; s++) begin
         cat        = {rem_st[s], rad_st[s][2*RW-1:2*RW-2]};
         trial      = {2'b00, root_st[s], 2'b01};
         ge         = cat >= trial;
         rem_in[s]  = ge ? (cat[RW+1:0] - trial[RW+1:0]) : cat[RW+1:0];
         root_in[s] = {root_st[s][RW-2:0], ge};
         rad_in[s]  = {rad_st[s][2*RW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_st[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < RW; s++) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            side_ff[s] <= side_st[s];
         end
      end
   end

   assign out_valid = valid_st[RW];
   assign out_root  = root_st[RW];
   assign out_side  = side_st[RW];

endmodule

[design/cfi_div.sv]
module cfi_div #(
   parameter int LANES  = 1,
   parameter int QW     = 32,
   parameter int DW     = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DW-1:0]     in_rem [LANES],
   input  logic [QW-1:0]     in_num [LANES],
   input  logic [DW-1:0]     in_div,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QW-1:0]     out_quo [LANES],
   output logic [SIDE_W-1:0] out_side
);

   logic [DW-1:0]     rem_st  [QW+1][LANES];
   logic [QW-1:0]     num_st  [QW+1][LANES];
   logic [DW-1:0]     div_st  [QW+1];
   logic [SIDE_W-1:0] side_st [QW+1];
   logic [QW:0]       valid_st;

   logic [DW-1:0]     rem_ff  [QW][LANES];
   logic [QW-1:0]     num_ff  [QW][LANES];
   logic [DW-1:0]     div_ff  [QW];
   logic [SIDE_W-1:0] side_ff [QW];
   logic [QW-1:0]     valid_ff;

   logic [DW-1:0]     rem_in  [QW][LANES];
   logic [QW-1:0]     num_in  [QW][LANES];

   always_comb begin
      rem_st[0]   = in_rem;
      num_st[0]   = in_num;
      div_st[0]   = in_div;
      side_st[0]  = in_side;
      valid_st[0] = in_valid;
      for (int s = 0; s < QW; s++) begin
         rem_st[s+1]   = rem_ff[s];
         num_st[s+1]   = num_ff[s];
         div_st[s+1]   = div_ff[s];
         side_st[s+1]  = side_ff[s];
         valid_st[s+1] = valid_ff[s];
      end
   end

   // restoring step: quotient bits shift in at the bottom of the numerator
   always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int s = 0; s < QW; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial        = {rem_st[s][l], num_st[s][l][QW-1]};
            ge           = trial >= {1'b0, div_st[s]};
            rem_in[s][l] = ge ? (trial[DW-1:0] - div_st[s]) : trial[DW-1:0];
            num_in[s][l] = {num_st[s][l][QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_st[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QW; s++) begin
            rem_ff[s]  <= rem_in[s];
            num_ff[s]  <= num_in[s];
            div_ff[s]  <= div_st[s];
            side_ff[s] <= side_st[s];
         end
      end
   end

   assign out_valid = valid_st[QW];
   assign out_quo   = num_st[QW];
   assign out_side  = side_st[QW];

endmodule

[design/coulomb_friction_impulse_unit.sv]
// Coulomb friction impulse for one contact per transfer, fully pipelined: a new contact
// is taken every cycle unless the result side stalls, and one result leaves per contact,
// in order. The pipeline has six stages for the dot product, tangent and squared length,
// 32 stages of the bit-serial square root, 32 + FRAC_BITS stages of the sliding-stop
// divide, two stages for the clamp and the magnitude products, 31 stages of the
// three-lane direction divide and the output register. A stall on the result side freezes
// the whole pipeline, so req_ready is high when rsp_ready is high or no result is held.
module coulomb_friction_impulse_unit
   import cfi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int QR_W  = WORD_W + FRAC_BITS;
   localparam int CMP_W = (QR_W > LIM_W) ? QR_W : LIM_W;
   localparam int MAG_W = WORD_W - 1;
   localparam int PRD_W = WORD_W + MAG_W;

   typedef struct packed {
      logic signed [WORD_W-1:0] den;
      logic [LIM_W-1:0]         slim;
      logic [LIM_W-1:0]         dlim;
   } ctx_type;

   typedef struct packed {
      logic [2:0][WORD_W-1:0] mag;
      logic [2:0]             neg;
      ctx_type                ctx;
   } sq_side_type;

   typedef struct packed {
      logic [2:0][WORD_W-1:0] mag;
      logic [2:0]             neg;
      logic [LIM_W-1:0]       slim;
      logic [LIM_W-1:0]       dlim;
      logic [WORD_W-1:0]      len;
      logic                   skip;
   } rd_side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic [1:0] regime;
   } id_side_type;

   logic [6:1] valid_ff;
   logic       v7_ff, v8_ff, rsp_valid_ff;

   logic en;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   logic signed [WORD_W-1:0] nrm1_ff [3];
   logic signed [WORD_W-1:0] vel1_ff [3];
   logic signed [63:0]       p1_ff   [3];
   ctx_type                  ctx1_ff;

   logic signed [WORD_W-1:0] nrm2_ff [3];
   logic signed [WORD_W-1:0] vel2_ff [3];
   logic signed [WORD_W-1:0] d2_ff;
   ctx_type                  ctx2_ff;

   logic signed [WORD_W-1:0] vel3_ff [3];
   logic signed [63:0]       q3_ff   [3];
   ctx_type                  ctx3_ff;

   logic signed [WORD_W-1:0] t4_ff   [3];
   ctx_type                  ctx4_ff;

   logic [WORD_W-1:0]        mag5_ff [3];
   logic [63:0]              sq5_ff  [3];
   logic [2:0]               neg5_ff;
   ctx_type                  ctx5_ff;

   logic [63:0]              sum6_ff;
   sq_side_type              side6_ff;

   logic [MAG_W-1:0]         m7_ff;
   logic [1:0]               regime7_ff;
   logic [2:0][WORD_W-1:0]   mag7_ff;
   logic [2:0]               neg7_ff;
   logic [WORD_W-1:0]        len7_ff;

   logic [PRD_W-1:0]         prd8_ff [3];
   logic [WORD_W-1:0]        len8_ff;
   id_side_type              side8_ff;

   rsp_type                  rsp_ff;

   logic signed [SAT_IN_W-1:0] dsum;
   logic signed [WORD_W-1:0]   tang [3];
   logic [WORD_W-1:0]          tabs [3];

   always_comb begin
      dsum = (SAT_IN_W'(p1_ff[0]) + SAT_IN_W'(p1_ff[1]) + SAT_IN_W'(p1_ff[2])) >>> FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         tang[i] = sat_s32(SAT_IN_W'(vel3_ff[i]) - SAT_IN_W'(q3_ff[i] >>> FRAC_BITS));
         tabs[i] = t4_ff[i][WORD_W-1] ? (~t4_ff[i] + 1'b1) : t4_ff[i];
      end
   end

   // square root
   logic        sq_valid;
   logic [WORD_W-1:0] sq_root;
   sq_side_type sq_side;

   cfi_isqrt #(
      .RW     (WORD_W),
      .SIDE_W ($bits(sq_side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_ff[6]),
      .in_rad    (sum6_ff),
      .in_side   (side6_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // sliding-stop ratio len / denom
   logic [WORD_W-1:0] rd_rem [1];
   logic [QR_W-1:0]   rd_num [1];
   logic [QR_W-1:0]   rd_quo [1];
   logic              rd_valid;
   rd_side_type       rd_side_in, rd_side;

   always_comb begin
      rd_rem[0]       = '0;
      rd_num[0]       = {sq_root, {FRAC_BITS{1'b0}}};
      rd_side_in.mag  = sq_side.mag;
      rd_side_in.neg  = sq_side.neg;
      rd_side_in.slim = sq_side.ctx.slim;
      rd_side_in.dlim = sq_side.ctx.dlim;
      rd_side_in.len  = sq_root;
      rd_side_in.skip = (sq_root == '0) || sq_side.ctx.den[WORD_W-1] || (sq_side.ctx.den == '0);
   end

   cfi_div #(
      .LANES  (1),
      .QW     (QR_W),
      .DW     (WORD_W),
      .SIDE_W ($bits(rd_side_type))
   ) u_rdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_rem    (rd_rem),
      .in_num    (rd_num),
      .in_div    (sq_side.ctx.den),
      .in_side   (rd_side_in),
      .out_valid (rd_valid),
      .out_quo   (rd_quo),
      .out_side  (rd_side)
   );

   // clamp: none when skipped, stick below the static bound, else slide
   logic [MAG_W-1:0] m_in;
   logic [1:0]       regime_in;

   always_comb begin
      if (rd_side.skip) begin
         m_in      = '0;
         regime_in = REGIME_NONE;
      end else if (CMP_W'(rd_quo[0]) < CMP_W'(rd_side.slim)) begin
         m_in      = (rd_quo[0][QR_W-1:MAG_W] != '0) ? '1 : rd_quo[0][MAG_W-1:0];
         regime_in = REGIME_STICK;
      end else begin
         m_in      = (rd_side.dlim[LIM_W-1:MAG_W] != '0) ? '1 : rd_side.dlim[MAG_W-1:0];
         regime_in = REGIME_SLIDE;
      end
   end

   // direction divide: |t| * m / len, quotient fits below 2^31 since |t| <= len
   logic [WORD_W-1:0] id_rem [3];
   logic [MAG_W-1:0]  id_num [3];
   logic [MAG_W-1:0]  id_quo [3];
   logic              id_valid;
   id_side_type       id_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         id_rem[i] = prd8_ff[i][PRD_W-1:MAG_W];
         id_num[i] = prd8_ff[i][MAG_W-1:0];
      end
   end

   cfi_div #(
      .LANES  (3),
      .QW     (MAG_W),
      .DW     (WORD_W),
      .SIDE_W ($bits(id_side_type))
   ) u_idiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_rem    (id_rem),
      .in_num    (id_num),
      .in_div    (len8_ff),
      .in_side   (side8_ff),
      .out_valid (id_valid),
      .out_quo   (id_quo),
      .out_side  (id_side)
   );

   logic signed [WORD_W-1:0] imp [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (id_side.regime == REGIME_NONE) begin
            imp[i] = '0;
         end else if (id_side.neg[i]) begin
            imp[i] = WORD_W'(id_quo[i]);
         end else begin
            imp[i] = -WORD_W'(id_quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[5:1], req_valid};
         v7_ff        <= rd_valid;
         v8_ff        <= v7_ff;
         rsp_valid_ff <= id_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: dot product terms and friction bounds
         nrm1_ff[0]   <= req_payload.normal_x;
         nrm1_ff[1]   <= req_payload.normal_y;
         nrm1_ff[2]   <= req_payload.normal_z;
         vel1_ff[0]   <= req_payload.vel_x;
         vel1_ff[1]   <= req_payload.vel_y;
         vel1_ff[2]   <= req_payload.vel_z;
         p1_ff[0]     <= 64'(req_payload.vel_x) * 64'(req_payload.normal_x);
         p1_ff[1]     <= 64'(req_payload.vel_y) * 64'(req_payload.normal_y);
         p1_ff[2]     <= 64'(req_payload.vel_z) * 64'(req_payload.normal_z);
         ctx1_ff.den  <= req_payload.denom;
         ctx1_ff.slim <= (LIM_W'(req_payload.static_coef) * LIM_W'(req_payload.normal_impulse))
                         >> FRAC_BITS;
         ctx1_ff.dlim <= (LIM_W'(req_payload.dynamic_coef) * LIM_W'(req_payload.normal_impulse))
                         >> FRAC_BITS;

         nrm2_ff <= nrm1_ff;
         vel2_ff <= vel1_ff;
         d2_ff   <= sat_s32(dsum);
         ctx2_ff <= ctx1_ff;

         vel3_ff <= vel2_ff;
         for (int i = 0; i < 3; i++) begin
            q3_ff[i] <= 64'(d2_ff) * 64'(nrm2_ff[i]);
         end
         ctx3_ff <= ctx2_ff;

         t4_ff   <= tang;
         ctx4_ff <= ctx3_ff;

         for (int i = 0; i < 3; i++) begin
            mag5_ff[i] <= tabs[i];
            sq5_ff[i]  <= 64'(tabs[i]) * 64'(tabs[i]);
            neg5_ff[i] <= t4_ff[i][WORD_W-1];
         end
         ctx5_ff <= ctx4_ff;

         sum6_ff <= sq5_ff[0] + sq5_ff[1] + sq5_ff[2];
         for (int i = 0; i < 3; i++) begin
            side6_ff.mag[i] <= mag5_ff[i];
         end
         side6_ff.neg <= neg5_ff;
         side6_ff.ctx <= ctx5_ff;

         m7_ff      <= m_in;
         regime7_ff <= regime_in;
         mag7_ff    <= rd_side.mag;
         neg7_ff    <= rd_side.neg;
         len7_ff    <= rd_side.len;

         for (int i = 0; i < 3; i++) begin
            prd8_ff[i] <= PRD_W'(mag7_ff[i]) * PRD_W'(m7_ff);
         end
         len8_ff         <= len7_ff;
         side8_ff.neg    <= neg7_ff;
         side8_ff.regime <= regime7_ff;

         rsp_ff.impulse_x <= imp[0];
         rsp_ff.impulse_y <= imp[1];
         rsp_ff.impulse_z <= imp[2];
         rsp_ff.regime    <= id_side.regime;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[tb/coulomb_friction_impulse_unit_tb.sv]
`timescale 1ns / 100ps

module coulomb_friction_impulse_unit_tb;
   import cfi_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int PIPE_DEPTH = 2 * 32 + FB + 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   rsp_type expected_impulses[$];
   int      mismatch_count;
   bit      timed_out;
   bit      calm_mode;
   int      hold_off_cycles;

   coulomb_friction_impulse_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp_s32(input logic signed [127:0] x);
      if (x > 128'sd2147483647) return 64'sd2147483647;
      if (x < -128'sd2147483648) return -64'sd2147483648;
      return x[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [127:0] v);
      logic [127:0] lo;
      logic [127:0] hi;
      logic [127:0] mid;
      lo = 0;
      hi = 128'd1 << 34;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo[63:0];
   endfunction

   // floor division by 2^FB on signed values
   function automatic logic signed [127:0] floor_div_frac(input logic signed [127:0] x);
      return x >>> FB;
   endfunction

   function automatic rsp_type friction_impulse(input req_type c);
      logic signed [127:0] nv[3];
      logic signed [127:0] vv[3];
      logic signed [127:0] tv[3];
      logic signed [127:0] dot_sum;
      logic signed [127:0] dotp;
      logic [127:0] sumsq;
      logic [127:0] len;
      logic [127:0] rr;
      logic [127:0] sb;
      logic [127:0] mag;
      logic [127:0] mag_abs;
      logic signed [127:0] q;
      rsp_type o;
      nv[0] = c.normal_x; nv[1] = c.normal_y; nv[2] = c.normal_z;
      vv[0] = c.vel_x;    vv[1] = c.vel_y;    vv[2] = c.vel_z;
      dot_sum = 0;
      for (int i = 0; i < 3; i++) dot_sum += vv[i] * nv[i];
      dotp = clamp_s32(floor_div_frac(dot_sum));
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         tv[i] = clamp_s32(vv[i] - floor_div_frac(dotp * nv[i]));
         mag_abs = tv[i] < 0 ? -tv[i] : tv[i];
         sumsq += mag_abs * mag_abs;
      end
      len = int_sqrt(sumsq);
      o = '0;
      o.regime = REGIME_NONE;
      if (len == 0 || c.denom <= 0) return o;
      rr = (len << FB) / 128'(unsigned'(64'(c.denom)));
      sb = (128'(c.static_coef) * 128'(c.normal_impulse)) >> FB;
      if (rr < sb) begin
         mag = rr;
         o.regime = REGIME_STICK;
      end else begin
         mag = (128'(c.dynamic_coef) * 128'(c.normal_impulse)) >> FB;
         o.regime = REGIME_SLIDE;
      end
      if (mag > 128'd2147483647) mag = 128'd2147483647;
      for (int i = 0; i < 3; i++) begin
         mag_abs = tv[i] < 0 ? -tv[i] : tv[i];
         q = (mag_abs * mag) / len;
         q = clamp_s32(tv[i] > 0 ? -q : q);
         case (i)
            0: o.impulse_x = q[31:0];
            1: o.impulse_y = q[31:0];
            default: o.impulse_z = q[31:0];
         endcase
      end
      return o;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(0, 131072)) - 65536);
         3: return $urandom();
         default: return 32'(signed'($urandom_range(0, 8388608)) - 4194304);
      endcase
   endfunction

   function automatic logic [18:0] rand_coef();
      case ($urandom_range(0, 7))
         0: return 19'd0;
         1: return 19'd262144;
         2: return 19'($urandom());
         default: return 19'($urandom_range(0, 262144));
      endcase
   endfunction

   task automatic send_contact(input req_type c);
      if (!calm_mode) begin
         while ($urandom_range(0, 99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= c;
      expected_impulses.push_back(friction_impulse(c));
      do @(posedge clock); while (!req_ready);
   endtask

   // roughly unit normal along a random axis with small tilt, or a wild normal one time in ten
   function automatic req_type rand_contact();
      req_type c;
      int axis;
      c.normal_x = 32'($signed($urandom_range(0, 8192)) - 4096);
      c.normal_y = 32'($signed($urandom_range(0, 8192)) - 4096);
      c.normal_z = 32'($signed($urandom_range(0, 8192)) - 4096);
      axis = $urandom_range(0, 2);
      if (axis == 0) c.normal_x = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
      if (axis == 1) c.normal_y = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
      if (axis == 2) c.normal_z = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
      c.vel_x = rand_word();
      c.vel_y = rand_word();
      c.vel_z = rand_word();
      c.normal_impulse = $urandom_range(0, 3) == 0 ? 31'($urandom()) :
                         31'($urandom_range(0, 1 << 20));
      c.denom = $urandom_range(0, 5) == 0 ? rand_word() :
                32'($urandom_range(1, 1 << 20));
      c.static_coef  = rand_coef();
      c.dynamic_coef = rand_coef();
      if ($urandom_range(0, 9) == 0) begin
         c.normal_x = rand_word();
         c.normal_y = rand_word();
         c.normal_z = rand_word();
      end
      return c;
   endfunction

   task automatic test_directed();
      req_type c;
      c = '0;
      send_contact(c);
      c.normal_z = 32'sd65536; c.vel_z = 32'sd12345; c.denom = 32'sd65536;
      c.static_coef = 19'd65536; c.dynamic_coef = 19'd32768; c.normal_impulse = 31'd65536;
      send_contact(c);                                   // velocity along normal only
      c.vel_x = 32'sd1000;
      send_contact(c);                                   // sticks
      c.vel_x = 32'sd1000000;
      send_contact(c);                                   // slides
      c.denom = 32'sd0;
      send_contact(c);
      c.denom = -32'sd65536;
      send_contact(c);
      c.denom = 32'sd1; c.static_coef = 19'd262144;
      c.normal_impulse = 31'h7fff_ffff;
      send_contact(c);                                   // sliding ratio wider than 32 bits
      c.static_coef = 19'd0; c.dynamic_coef = 19'd262144;
      send_contact(c);                                   // no static bound
      c.denom = 32'h7fff_ffff;
      send_contact(c);
      c.vel_x = 32'h8000_0000; c.vel_y = 32'h7fff_ffff; c.vel_z = 32'h8000_0000;
      c.static_coef = 19'h7ffff; c.dynamic_coef = 19'h7ffff;
      send_contact(c);
      c.normal_x = 32'h8000_0000; c.normal_y = 32'h7fff_ffff; c.normal_z = 32'h8000_0000;
      send_contact(c);                                   // wild normal saturates
      c.normal_x = 32'hffff_ffff; c.normal_y = 32'h7fff_ffff; c.normal_z = 32'h0;
      c.vel_x = 32'hffff_ffff; c.vel_y = 32'h1; c.vel_z = 32'h7fff_ffff;
      c.denom = 32'sd65536;
      send_contact(c);
      c = '1;
      send_contact(c);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_contact(rand_contact());
   endtask

   task automatic test_calm_stream(input int count);
      calm_mode = 1'b1;
      for (int i = 0; i < count; i++) send_contact(rand_contact());
      calm_mode = 1'b0;
   endtask

   // sink stops long enough for the pipeline to fill and push back
   task automatic test_backpressure(input int count);
      hold_off_cycles = 3 * PIPE_DEPTH;
      for (int i = 0; i < count; i++) send_contact(rand_contact());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm_mode ? 1'b1 : ($urandom_range(0, 99) >= 22);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_impulses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transfer %h", rsp_payload);
         end else begin
            want = expected_impulses.pop_front();
            if (rsp_payload.impulse_x !== want.impulse_x ||
                rsp_payload.impulse_y !== want.impulse_y ||
                rsp_payload.impulse_z !== want.impulse_z ||
                rsp_payload.regime !== want.regime) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d %0d %0d r%0d, got %0d %0d %0d r%0d",
                     want.impulse_x, want.impulse_y, want.impulse_z, want.regime,
                     rsp_payload.impulse_x, rsp_payload.impulse_y,
                     rsp_payload.impulse_z, rsp_payload.regime);
            end
         end
      end
   end

   initial begin
      #2000000;
      timed_out = 1'b1;
      $display("coulomb_friction_impulse_unit_tb: errors");
      $finish;
   end

   initial begin
      int drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      mismatch_count = 0;
      timed_out = 1'b0;
      calm_mode = 1'b0;
      hold_off_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_calm_stream(150);
      test_backpressure(200);
      req_valid <= 1'b0;
      while (expected_impulses.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < PIPE_DEPTH + 20) begin
         @(posedge clock);
         drain++;
      end
      if (mismatch_count == 0 && expected_impulses.size() == 0)
         $display("coulomb_friction_impulse_unit_tb: clean");
      else
         $display("coulomb_friction_impulse_unit_tb: errors");
      $finish;
   end

endmodule

[sim.f]
design/cfi_pkg.sv
design/cfi_isqrt.sv
design/cfi_div.sv
design/coulomb_friction_impulse_unit.sv
tb/coulomb_friction_impulse_unit_tb.sv
